@@ hdl/bdq_pkg.sv @@
// Types and constants shared by the bounded deque and its storage cells.
package bdq_pkg;

	localparam int WORD_W = 32;
	localparam int CAP_W  = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_REAR  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_REAR   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     ok;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] rear_value;
		logic                     is_empty;
		logic                     is_full;
	} rsp_t;

	// Per-cycle commands broadcast to every cell.
	// f_* act on the front-aligned chain, r_* on the rear-aligned chain.
	typedef struct packed {
		logic grow;
		logic shrink;
		logic f_push;
		logic f_pop;
		logic f_app;
		logic r_push;
		logic r_pop;
		logic r_app;
	} ctrl_t;

endpackage

@@ hdl/bounded_double_ended_queue.sv @@
// Top level of the bounded double-ended queue: control, cell row and result register.
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one operation per
//   transaction: push front, push rear, pop front or pop rear, with a word.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns one transaction per
//   request: ok flag, front and rear words (-1 when empty), empty and full.
//   cfg_wen/cfg_wdata write the capacity (reset 16); values above DEPTH act
//   as DEPTH, zero refuses every push. Write it only while idle.
// Timing:
//   The response appears in the cycle after the request is taken. One request per
//   cycle is sustained while rsp_stall holds no response; the row of DEPTH cells
//   updates every cell in the same cycle, the front word always sitting in cell 0
//   of one chain and the rear word in cell 0 of the other.
// Reset:
//   arst_n empties the deque and sets the capacity to 16. No clearing pass.
// Backpressure:
//   While a response is held by rsp_stall, req_stall is raised and no new
//   request is taken; the held response does not change.
module bounded_double_ended_queue import bdq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_wen,
	input  logic [CAP_W-1:0] cfg_wdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0]         cap_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nxt;
	logic                     rsp_valid_q;
	logic                     ok_q;
	logic                     empty_q;
	logic                     full_q;
	logic                     accept;
	logic                     full_now;
	logic                     full_nxt;
	logic                     ok_nxt;
	ctrl_t                    ctrl;
	logic signed [WORD_W-1:0] f_word [DEPTH];
	logic signed [WORD_W-1:0] r_word [DEPTH];
	logic [DEPTH-1:0]         occ;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign full_now = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q == CNT_W'(DEPTH));
	assign full_nxt = (CMP_W'(count_nxt) >= CMP_W'(cap_q)) ||
		(count_nxt == CNT_W'(DEPTH));

	always_comb begin
		ctrl   = '0;
		ok_nxt = 1'b0;
		unique case (req.kind)
			KIND_PUSH_FRONT: begin
				ok_nxt      = !full_now;
				ctrl.grow   = accept && ok_nxt;
				ctrl.f_push = ctrl.grow;
				ctrl.r_app  = ctrl.grow;
			end
			KIND_PUSH_REAR: begin
				ok_nxt      = !full_now;
				ctrl.grow   = accept && ok_nxt;
				ctrl.r_push = ctrl.grow;
				ctrl.f_app  = ctrl.grow;
			end
			KIND_POP_FRONT: begin
				ok_nxt      = (count_q != '0);
				ctrl.shrink = accept && ok_nxt;
				ctrl.f_pop  = ctrl.shrink;
			end
			KIND_POP_REAR: begin
				ok_nxt      = (count_q != '0);
				ctrl.shrink = accept && ok_nxt;
				ctrl.r_pop  = ctrl.shrink;
			end
			default: begin
				ok_nxt = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (ctrl.grow) begin
			count_nxt = count_q + 1'b1;
		end else if (ctrl.shrink) begin
			count_nxt = count_q - 1'b1;
		end else begin
			count_nxt = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			empty_q     <= 1'b1;
			full_q      <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cap_q <= cfg_wdata;
			end
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
				ok_q        <= ok_nxt;
				empty_q     <= (count_nxt == '0);
				full_q      <= full_nxt;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] f_left;
		logic signed [WORD_W-1:0] f_right;
		logic signed [WORD_W-1:0] r_left;
		logic signed [WORD_W-1:0] r_right;
		logic                     occ_left;
		logic                     occ_right;

		if (i == 0) begin : g_head
			assign f_left   = req.value;
			assign r_left   = req.value;
			assign occ_left = 1'b1;
		end else begin : g_body
			assign f_left   = f_word[i-1];
			assign r_left   = r_word[i-1];
			assign occ_left = occ[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign f_right   = '0;
			assign r_right   = '0;
			assign occ_right = 1'b0;
		end else begin : g_inner
			assign f_right   = f_word[i+1];
			assign r_right   = r_word[i+1];
			assign occ_right = occ[i+1];
		end

		bdq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.value     (req.value),
			.f_left    (f_left),
			.f_right   (f_right),
			.r_left    (r_left),
			.r_right   (r_right),
			.occ_left  (occ_left),
			.occ_right (occ_right),
			.f_word    (f_word[i]),
			.r_word    (r_word[i]),
			.occ       (occ[i])
		);
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp.ok          = ok_q;
	assign rsp.front_value = empty_q ? '1 : f_word[0];
	assign rsp.rear_value  = empty_q ? '1 : r_word[0];
	assign rsp.is_empty    = empty_q;
	assign rsp.is_full     = full_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_occ_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ) == int'(count_q))
		else $error("cell occupancy disagrees with entry count");

	a_pop_empty_refused: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (count_q == '0) &&
		(req.kind == KIND_POP_FRONT || req.kind == KIND_POP_REAR)
		|=> !ok_q && empty_q)
		else $error("pop on empty deque not refused");

	a_empty_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (empty_q == (count_q == '0)))
		else $error("empty flag disagrees with entry count");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=> $stable(count_q))
		else $error("state changed while response held");
`endif

endmodule

@@ hdl/bdq_cell.sv @@
// One storage cell: a front-chain word, a rear-chain word and an occupancy bit.
module bdq_cell import bdq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_t                    ctrl,
	input  logic signed [WORD_W-1:0] value,
	input  logic signed [WORD_W-1:0] f_left,
	input  logic signed [WORD_W-1:0] f_right,
	input  logic signed [WORD_W-1:0] r_left,
	input  logic signed [WORD_W-1:0] r_right,
	input  logic                     occ_left,
	input  logic                     occ_right,
	output logic signed [WORD_W-1:0] f_word,
	output logic signed [WORD_W-1:0] r_word,
	output logic                     occ
);

	logic signed [WORD_W-1:0] f_q;
	logic signed [WORD_W-1:0] r_q;
	logic                     occ_q;
	logic                     first_free;

	assign first_free = occ_left && !occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.grow) begin
			occ_q <= occ_left;
		end else if (ctrl.shrink) begin
			occ_q <= occ_right;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.f_push) begin
			f_q <= f_left;
		end else if (ctrl.f_pop) begin
			f_q <= f_right;
		end else if (ctrl.f_app && first_free) begin
			f_q <= value;
		end
		if (ctrl.r_push) begin
			r_q <= r_left;
		end else if (ctrl.r_pop) begin
			r_q <= r_right;
		end else if (ctrl.r_app && first_free) begin
			r_q <= value;
		end
	end

	assign f_word = f_q;
	assign r_word = r_q;
	assign occ    = occ_q;

endmodule
